@@ src/imptt_pkg.sv @@
// Shared types and constants of the indexed max-priority task table.
// No dependencies; used by the top level and imptt_scan.
package imptt_pkg;

  localparam int TaskSlotsDef    = 256;
  localparam int PriorityBitsDef = 32;
  localparam int UserBitsDef     = 16;

  // Field widths of the stream beats
  localparam int OpW       = 2;
  localparam int TaskIdW   = 8;
  localparam int UserIdW   = 16;
  localparam int PrioReqW  = 32;
  localparam int InDataW   = 56;
  localparam int OutDataW  = 16;

  typedef enum logic [OpW-1:0] {
    OP_ADD    = 2'd0,
    OP_EDIT   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_EXEC   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_EDIT,
    ST_SCAN,
    ST_TAIL,
    ST_RETIRE
  } state_e;

  typedef struct packed {
    logic clear;
    logic sample;
  } scan_ctrl_t;

endpackage

@@ src/indexed_max_priority_task_table_unit.sv @@
// Top level of the indexed max-priority task table: control sequencer,
// slot memory and output register. Depends on imptt_pkg, imptt_ram, imptt_scan.
//
// channel  dir  tdata (low bit up)                               tuser
// s_axis   in   task_id[7:0] user_id[23:8] priority_req[55:24]   operation[1:0]
// m_axis   out  owner_user[15:0]                                 found[0]
//
// Add and remove write in the dispatch state; edit reads there, then writes back.
// Execute-top makes one memory read per slot, then
// the winner's slot is written back with its valid mark cleared.
// After reset a clearing pass writes zero to every slot of the slot memory;
// s_axis_tready_o stays low meanwhile.
// A waiting result does not block input; a new execute-top holds its result
// until the output register is free.
module indexed_max_priority_task_table_unit #(
  parameter int TASK_SLOTS    = imptt_pkg::TaskSlotsDef,
  parameter int PRIORITY_BITS = imptt_pkg::PriorityBitsDef,
  parameter int USER_BITS     = imptt_pkg::UserBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // task_id[7:0], user_id[23:8], priority_req[55:24]
  input  logic [imptt_pkg::InDataW-1:0] s_axis_tdata_i,
  // operation[1:0]
  input  logic [imptt_pkg::OpW-1:0]     s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // owner_user[15:0]
  output logic [imptt_pkg::OutDataW-1:0] m_axis_tdata_o,
  // found[0]
  output logic                          m_axis_tuser_o
);

  localparam int IdxBits = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int WordW   = 1 + PRIORITY_BITS + USER_BITS;
  localparam logic [IdxBits-1:0] LastIdx = IdxBits'(TASK_SLOTS - 1);
  localparam logic [16:0] SlotsW = 17'(TASK_SLOTS);

  imptt_pkg::state_e state_q, state_d;
  logic [IdxBits-1:0] cnt_q, cnt_d;

  imptt_pkg::op_e            op_q;
  logic [IdxBits-1:0]        idx_q;
  logic [PRIORITY_BITS-1:0]  prio_q;
  logic [USER_BITS-1:0]      user_q;
  logic                      in_range_q;

  logic               sample_q;
  logic [IdxBits-1:0] sample_idx_q;

  logic               we;
  logic [IdxBits-1:0] waddr;
  logic [WordW-1:0]   wdata;
  logic [IdxBits-1:0] raddr;
  logic [WordW-1:0]   rdata;

  logic                     rd_valid;
  logic [PRIORITY_BITS-1:0] rd_prio;
  logic [USER_BITS-1:0]     rd_owner;

  imptt_pkg::scan_ctrl_t scan_ctrl;
  logic                  have;
  logic [IdxBits-1:0]    best_idx;
  logic [USER_BITS-1:0]  best_owner;

  logic                             out_load;
  logic                             m_valid_q;
  logic                             m_found_q;
  logic [imptt_pkg::OutDataW-1:0]   m_owner_q;

  logic accept;
  logic [imptt_pkg::TaskIdW-1:0] in_task_id;

  assign accept     = s_axis_tvalid_i && s_axis_tready_o;
  assign in_task_id = s_axis_tdata_i[7:0];

  // Memory word: {valid, priority, owner}
  assign rd_valid = rdata[WordW-1];
  assign rd_prio  = rdata[WordW-2:USER_BITS];
  assign rd_owner = rdata[USER_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q       <= imptt_pkg::op_e'(s_axis_tuser_i);
      idx_q      <= IdxBits'(in_task_id);
      user_q     <= USER_BITS'(s_axis_tdata_i[23:8]);
      prio_q     <= PRIORITY_BITS'(s_axis_tdata_i[55:24]);
      in_range_q <= 17'(in_task_id) < SlotsW;
    end
    sample_idx_q <= cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= imptt_pkg::ST_CLEAR;
      cnt_q    <= '0;
      sample_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      sample_q <= (state_q == imptt_pkg::ST_SCAN);
    end
  end

  always_comb begin
    state_d          = state_q;
    cnt_d            = cnt_q;
    we               = 1'b0;
    waddr            = idx_q;
    wdata            = '0;
    raddr            = cnt_q;
    s_axis_tready_o  = 1'b0;
    scan_ctrl.clear  = 1'b0;
    scan_ctrl.sample = sample_q;
    out_load         = 1'b0;
    unique case (state_q)
      imptt_pkg::ST_CLEAR: begin
        we    = 1'b1;
        waddr = cnt_q;
        if (cnt_q == LastIdx) begin
          cnt_d   = '0;
          state_d = imptt_pkg::ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      imptt_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          state_d = imptt_pkg::ST_DISPATCH;
        end
      end
      imptt_pkg::ST_DISPATCH: begin
        state_d = imptt_pkg::ST_IDLE;
        unique case (op_q)
          imptt_pkg::OP_ADD: begin
            we    = in_range_q;
            wdata = {1'b1, prio_q, user_q};
          end
          imptt_pkg::OP_EDIT: begin
            raddr = idx_q;
            if (in_range_q) begin
              state_d = imptt_pkg::ST_EDIT;
            end
          end
          imptt_pkg::OP_REMOVE: begin
            we = in_range_q;
          end
          imptt_pkg::OP_EXEC: begin
            scan_ctrl.clear = 1'b1;
            cnt_d           = '0;
            state_d         = imptt_pkg::ST_SCAN;
          end
          default: begin
            state_d = imptt_pkg::ST_IDLE;
          end
        endcase
      end
      imptt_pkg::ST_EDIT: begin
        // Only a present task takes the new priority.
        we      = rd_valid;
        wdata   = {1'b1, prio_q, rd_owner};
        state_d = imptt_pkg::ST_IDLE;
      end
      imptt_pkg::ST_SCAN: begin
        raddr = cnt_q;
        if (cnt_q == LastIdx) begin
          cnt_d   = '0;
          state_d = imptt_pkg::ST_TAIL;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      imptt_pkg::ST_TAIL: begin
        state_d = imptt_pkg::ST_RETIRE;
      end
      imptt_pkg::ST_RETIRE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          we       = have;
          waddr    = best_idx;
          state_d  = imptt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = imptt_pkg::ST_IDLE;
      end
    endcase
  end

  imptt_ram #(
    .Width (WordW),
    .Depth (TASK_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  imptt_scan #(
    .IdxBits      (IdxBits),
    .PriorityBits (PRIORITY_BITS),
    .UserBits     (USER_BITS)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (scan_ctrl),
    .idx_i        (sample_idx_q),
    .slot_valid_i (rd_valid),
    .slot_prio_i  (rd_prio),
    .slot_owner_i (rd_owner),
    .have_o       (have),
    .best_idx_o   (best_idx),
    .best_owner_o (best_owner)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_found_q <= have;
      m_owner_q <= have ? imptt_pkg::OutDataW'(best_owner) : '0;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_owner_q;
  assign m_axis_tuser_o  = m_found_q;

endmodule

@@ src/imptt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module imptt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/imptt_scan.sv @@
// Running maximum over the slot scan: keeps the best valid slot seen so far.
// Depends on imptt_pkg.
module imptt_scan #(
  parameter int IdxBits      = 8,
  parameter int PriorityBits = 32,
  parameter int UserBits     = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  imptt_pkg::scan_ctrl_t      ctrl_i,
  input  logic [IdxBits-1:0]         idx_i,
  input  logic                       slot_valid_i,
  input  logic [PriorityBits-1:0]    slot_prio_i,
  input  logic [UserBits-1:0]        slot_owner_i,
  output logic                       have_o,
  output logic [IdxBits-1:0]         best_idx_o,
  output logic [UserBits-1:0]        best_owner_o
);

  logic                    have_q;
  logic [PriorityBits-1:0] best_prio_q;
  logic [IdxBits-1:0]      best_idx_q;
  logic [UserBits-1:0]     best_owner_q;
  logic                    take;

  // Slots arrive in ascending order, so >= hands ties to the larger id.
  assign take = ctrl_i.sample && slot_valid_i && (!have_q || slot_prio_i >= best_prio_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      have_q <= 1'b0;
    end else if (take) begin
      have_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_prio_q  <= slot_prio_i;
      best_idx_q   <= idx_i;
      best_owner_q <= slot_owner_i;
    end
  end

  assign have_o       = have_q;
  assign best_idx_o   = best_idx_q;
  assign best_owner_o = best_owner_q;

endmodule

@@ tb/sv/indexed_max_priority_task_table_unit_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for indexed_max_priority_task_table_unit: drives command
// beats on s_axis, predicts execute-top grants from a local slot table and checks
// every m_axis beat. Depends on imptt_pkg and the block's RTL in src.
module indexed_max_priority_task_table_unit_test;

  localparam int Slots         = imptt_pkg::TaskSlotsDef;
  localparam int StallLimit    = 20000;
  localparam int HoldOffCycles = 3000;
  localparam int NumRandom     = 1475;

  typedef struct {
    imptt_pkg::op_e                 op;
    logic [imptt_pkg::TaskIdW-1:0]  task_id;
    logic [imptt_pkg::UserIdW-1:0]  user_id;
    logic [imptt_pkg::PrioReqW-1:0] prio;
  } cmd_t;

  typedef struct {
    logic                           found;
    logic [imptt_pkg::OutDataW-1:0] owner;
  } grant_t;

  logic                           clk_i    = 1'b0;
  logic                           rst_ni   = 1'b0;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [imptt_pkg::InDataW-1:0]  s_tdata  = '0;
  logic [imptt_pkg::OpW-1:0]      s_tuser  = imptt_pkg::OP_ADD;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [imptt_pkg::OutDataW-1:0] m_tdata;
  logic                           m_tuser;

  cmd_t   pending_cmds[$];
  grant_t expected_grants[$];

  // local copy of the slot table
  bit                             slot_live[Slots];
  logic [imptt_pkg::PrioReqW-1:0] slot_rank[Slots];
  logic [imptt_pkg::UserIdW-1:0]  slot_user[Slots];

  int errors       = 0;
  int beats_sent   = 0;
  int grants_seen  = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;
  int stall_cycles = 0;

  indexed_max_priority_task_table_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic predict_table_op(input imptt_pkg::op_e op,
                                  input logic [imptt_pkg::TaskIdW-1:0] id,
                                  input logic [imptt_pkg::UserIdW-1:0] user,
                                  input logic [imptt_pkg::PrioReqW-1:0] prio);
    grant_t g;
    int     best;
    case (op)
      imptt_pkg::OP_ADD: begin
        if (id < Slots) begin
          slot_live[id] = 1'b1;
          slot_rank[id] = prio;
          slot_user[id] = user;
        end
      end
      imptt_pkg::OP_EDIT: begin
        if (id < Slots && slot_live[id]) slot_rank[id] = prio;
      end
      imptt_pkg::OP_REMOVE: begin
        if (id < Slots) slot_live[id] = 1'b0;
      end
      default: begin
        best = -1;
        // >= lets the higher id win a priority tie
        for (int i = 0; i < Slots; i++)
          if (slot_live[i] && (best < 0 || slot_rank[i] >= slot_rank[best])) best = i;
        if (best >= 0) begin
          slot_live[best] = 1'b0;
          g.found = 1'b1;
          g.owner = slot_user[best];
        end else begin
          g.found = 1'b0;
          g.owner = '0;
        end
        expected_grants.push_back(g);
      end
    endcase
  endtask

  task automatic push_cmd(input imptt_pkg::op_e op, input int id, input int user,
                          input logic [31:0] prio);
    cmd_t c;
    c.op      = op;
    c.task_id = imptt_pkg::TaskIdW'(id);
    c.user_id = imptt_pkg::UserIdW'(user);
    c.prio    = prio;
    pending_cmds.push_back(c);
  endtask

  function automatic logic [imptt_pkg::PrioReqW-1:0] pick_prio();
    case ($urandom_range(0, 3))
      // crowd priorities to force ties
      0: return imptt_pkg::PrioReqW'($urandom_range(0, 7));
      1: return $urandom_range(0, 1) ? '1 : '0;
      default: return imptt_pkg::PrioReqW'($urandom);
    endcase
  endfunction

  // driver: a beat stays offered until taken; gaps only between beats
  always @(posedge clk_i or negedge rst_ni) begin
    cmd_t nxt;
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= imptt_pkg::OP_ADD;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        predict_table_op(imptt_pkg::op_e'(s_tuser), s_tdata[7:0], s_tdata[23:8],
                         s_tdata[55:24]);
        beats_sent++;
      end
      if (pending_cmds.size() != 0 &&
          ((beats_sent >= 700 && beats_sent < 1000) || $urandom_range(0, 99) >= 36)) begin
        nxt = pending_cmds.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {nxt.prio, nxt.user_id, nxt.task_id};
        s_tuser  <= nxt.op;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // monitor: checks grants in order, stalls at random, one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    grant_t want;
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        grants_seen++;
        if (expected_grants.size() == 0) begin
          $display("%0t: unexpected grant beat found=%0b owner=%h", $time, m_tuser, m_tdata);
          errors++;
        end else begin
          want = expected_grants.pop_front();
          if (m_tuser !== want.found) begin
            $display("%0t: found mismatch expected=%0b actual=%0b", $time, want.found, m_tuser);
            errors++;
          end
          if (m_tdata !== want.owner) begin
            $display("%0t: owner mismatch expected=%h actual=%h", $time, want.owner, m_tdata);
            errors++;
          end
        end
        if (grants_seen == 40 && !hold_done) begin
          hold_left = HoldOffCycles;
          hold_done = 1'b1;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (grants_seen >= 150 && grants_seen < 250) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= 36);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= StallLimit) begin
          $display("%0t: no beat moved for %0d cycles", $time, StallLimit);
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  initial begin
    int made;
    int mode;
    int burst;
    int r;
    imptt_pkg::op_e op;

    // directed: empty table, extremes, ties, absent edit/remove, overwrite
    push_cmd(imptt_pkg::OP_EXEC,   0,   0,        32'h0);
    push_cmd(imptt_pkg::OP_ADD,    0,   0,        32'h0);
    push_cmd(imptt_pkg::OP_ADD,    255, 16'hffff, 32'hffff_ffff);
    push_cmd(imptt_pkg::OP_ADD,    128, 16'h5a5a, 32'hffff_ffff);
    push_cmd(imptt_pkg::OP_EXEC,   0,   0,        32'h0);
    push_cmd(imptt_pkg::OP_EXEC,   0,   0,        32'h0);
    push_cmd(imptt_pkg::OP_EXEC,   0,   0,        32'h0);
    push_cmd(imptt_pkg::OP_EXEC,   0,   0,        32'h0);
    push_cmd(imptt_pkg::OP_EDIT,   7,   0,        32'hffff_ffff);
    push_cmd(imptt_pkg::OP_REMOVE, 9,   0,        32'h0);
    push_cmd(imptt_pkg::OP_ADD,    0,   16'h1234, 32'h0);
    push_cmd(imptt_pkg::OP_EDIT,   0,   0,        32'h5);
    push_cmd(imptt_pkg::OP_ADD,    3,   16'ha5a5, 32'h5);
    push_cmd(imptt_pkg::OP_ADD,    3,   16'h00ff, 32'h5);
    push_cmd(imptt_pkg::OP_ADD,    200, 16'h8001, 32'h4);
    push_cmd(imptt_pkg::OP_EXEC,   0,   0,        32'h0);
    push_cmd(imptt_pkg::OP_REMOVE, 0,   0,        32'h0);
    push_cmd(imptt_pkg::OP_EXEC,   0,   0,        32'h0);
    push_cmd(imptt_pkg::OP_EXEC,   0,   0,        32'h0);
    push_cmd(imptt_pkg::OP_ADD,    1,   16'h7fff, 32'h8000_0000);
    push_cmd(imptt_pkg::OP_ADD,    2,   16'hfffe, 32'h7fff_ffff);
    push_cmd(imptt_pkg::OP_EXEC,   0,   0,        32'h0);
    push_cmd(imptt_pkg::OP_EDIT,   2,   0,        32'h0);
    push_cmd(imptt_pkg::OP_EXEC,   0,   0,        32'h0);
    push_cmd(imptt_pkg::OP_EXEC,   0,   0,        32'h0);

    // random bursts: mostly mixed traffic on a small id pool so edits and
    // removes hit live tasks, some full-range traffic, some draining exec runs
    made = 0;
    while (made < NumRandom) begin
      mode  = $urandom_range(0, 9);
      burst = $urandom_range(8, 30);
      for (int k = 0; k < burst && made < NumRandom; k++) begin
        r = $urandom_range(0, 99);
        if (mode == 0)    op = imptt_pkg::OP_EXEC;
        else if (r < 40)  op = imptt_pkg::OP_ADD;
        else if (r < 60)  op = imptt_pkg::OP_EDIT;
        else if (r < 75)  op = imptt_pkg::OP_REMOVE;
        else              op = imptt_pkg::OP_EXEC;
        push_cmd(op, (mode < 6) ? $urandom_range(0, 15) : $urandom_range(0, 255),
                 $urandom_range(0, 65535), pick_prio());
        made++;
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_cmds.size() != 0 || s_tvalid) @(posedge clk_i);
    while (expected_grants.size() != 0) @(posedge clk_i);
    repeat (Slots + 8) @(posedge clk_i);

    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
